>>> rtl/npsrch_pkg.sv
// ----------------------------------------------------------------------------
// npsrch_pkg
// Shared types and codes of the prime search block: operation codes, engine
// states and the status bundle of the serial divider.
// ----------------------------------------------------------------------------
package npsrch_pkg;

	// Operation codes carried by the opcode field
	localparam logic [1:0] OP_UP_ANY   = 2'd0;
	localparam logic [1:0] OP_DOWN_ANY = 2'd1;
	localparam logic [1:0] OP_UP_34    = 2'd2;
	localparam logic [1:0] OP_DOWN_34  = 2'd3;

	// First odd trial divisor and the stride between candidates and divisors
	localparam int unsigned FIRST_DIVISOR = 3;
	localparam int unsigned ODD_STRIDE    = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TRIAL,
		ST_WAIT,
		ST_DONE
	} npsrch_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} npsrch_div_stat_t;

endpackage

>>> rtl/npsrch_div.sv
// ----------------------------------------------------------------------------
// npsrch_div
// Radix-2 restoring divider: the dividend shifts out MSB first and one
// quotient bit shifts in per cycle while busy.
// ----------------------------------------------------------------------------
module npsrch_div
	import npsrch_pkg::*;
#(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder,
	output npsrch_div_stat_t stat
);

	localparam int unsigned CW = $clog2(WIDTH);

	logic [WIDTH-1:0] shift_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             qbit;

	always_comb begin
		trial = {rem_q, shift_q[WIDTH-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			dvs_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[WIDTH-2:0], qbit};
			rem_q   <= qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
		end
	end

	assign quotient  = shift_q;
	assign remainder = rem_q;
	assign stat      = '{busy: busy_q, done: done_q};

endmodule

>>> rtl/next_prime_search.sv
// ----------------------------------------------------------------------------
// next_prime_search
// Searches up or down from a start value for the nearest odd prime, or the
// nearest odd prime congruent to 3 mod 4, by trial division.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, start_value, opcode   | into block
//  result  | out_valid, out_ready, prime_value, found  | out of block
//
//  Each trial division launches the bit-serial divider (one quotient bit per
//  cycle) in ST_TRIAL and evaluates its quotient and remainder in ST_WAIT.
//  Each candidate passes ST_CHECK for its range and 3 mod 4 check, then,
//  unless its residue is skipped, one division per odd divisor up to its
//  square root or the first divisor that divides it; the out-of-range
//  candidate that ends a miss gets no trials.
//  The engine result passes through the output register to the port.
//  Reset clears only control state: engine, divider and the result valid flag.
//  A stalled result holds in the output register; the engine takes the next
//  item meanwhile and parks its own result until the register frees.
//
module next_prime_search
	import npsrch_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] start_value,
	input  logic [1:0]  opcode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] prime_value,
	output logic        found
);

	localparam int unsigned W = VALUE_WIDTH;
	// Signed maximum: the candidate limit, never itself tested
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] STEP_UP   = W'(ODD_STRIDE);
	localparam logic [W-1:0] STEP_DOWN = ~W'(ODD_STRIDE) + 1'b1;

	npsrch_state_t state_q, state_d;

	logic [W-1:0] start_q;
	logic [W-1:0] cand_q;
	logic [W-1:0] div_q;
	logic         down_q;
	logic         need34_q;
	logic [W-1:0] res_q;
	logic         hit_q;

	logic         out_valid_q;
	logic [31:0]  prime_q;
	logic         found_q;

	// Width adaptation of the 32-bit ports to the working width
	logic [W+31:0] start_ext;
	logic [W-1:0]  start_w;
	logic [W+31:0] res_ext;

	logic [W-1:0]  quot;
	logic [W-1:0]  rem;
	npsrch_div_stat_t div_stat;
	logic          div_start;

	logic          dec_down;
	logic          dec_need34;
	logic          in_fire;
	logic          out_free;
	logic [W-1:0]  cand_next;
	logic          in_range;
	logic          skip34;

	assign start_ext = {{W{1'b0}}, start_value};
	assign start_w   = start_ext[W-1:0];
	assign res_ext   = {32'd0, res_q};

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cand_next = cand_q + (down_q ? STEP_DOWN : STEP_UP);
	assign in_range  = (cand_q < SMAX) && (cand_q != '0);
	assign skip34    = need34_q && (cand_q[1:0] != 2'b11);

	// Decode search direction and residue filter
	always_comb begin
		unique case (opcode)
			OP_UP_ANY:   begin dec_down = 1'b0; dec_need34 = 1'b0; end
			OP_DOWN_ANY: begin dec_down = 1'b1; dec_need34 = 1'b0; end
			OP_UP_34:    begin dec_down = 1'b0; dec_need34 = 1'b1; end
			OP_DOWN_34:  begin dec_down = 1'b1; dec_need34 = 1'b1; end
			default:     begin dec_down = 1'b0; dec_need34 = 1'b0; end
		endcase
	end

	npsrch_div #(
		.WIDTH(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cand_q),
		.divisor  (div_q),
		.quotient (quot),
		.remainder(rem),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// Out of range: give up. Wrong residue: advance.
				if (!in_range) begin
					state_d = ST_DONE;
				end else if (!skip34) begin
					state_d = ST_TRIAL;
				end
			end
			ST_TRIAL: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_stat.done) begin
					if (div_q > quot) begin
						// Divisors exhausted: prime unless the candidate is one
						state_d = (cand_q != W'(1)) ? ST_DONE : ST_CHECK;
					end else if (rem == '0) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_TRIAL;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Engine datapath: no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					start_q  <= start_w;
					cand_q   <= start_w | W'(1);
					down_q   <= dec_down;
					need34_q <= dec_need34;
				end
			end
			ST_CHECK: begin
				if (!in_range) begin
					res_q <= start_q;
					hit_q <= 1'b0;
				end else if (skip34) begin
					cand_q <= cand_next;
				end else begin
					div_q <= W'(FIRST_DIVISOR);
				end
			end
			ST_WAIT: begin
				if (div_stat.done) begin
					if (div_q > quot) begin
						if (cand_q != W'(1)) begin
							res_q <= cand_q;
							hit_q <= 1'b1;
						end else begin
							cand_q <= cand_next;
						end
					end else if (rem == '0) begin
						cand_q <= cand_next;
					end else begin
						div_q <= div_q + W'(ODD_STRIDE);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			prime_q <= res_ext[31:0];
			found_q <= hit_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign prime_value = prime_q;
	assign found       = found_q;

endmodule

>>> rtl/npsrch_checker.sv
// ----------------------------------------------------------------------------
// npsrch_checker
// Port-level checks of the prime search block, bound to the top level.
// ----------------------------------------------------------------------------
module npsrch_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] start_value,
	input logic [1:0]  opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] prime_value,
	input logic        found
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_value) && $stable(found))
		else $error("result changed while stalled");

	// One item at a time: the engine is busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while engine busy");

	// A fresh result comes from a busy engine
	a_result_from_engine: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared from an idle engine");

	// Every prime returned is odd
	a_found_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> prime_value[0])
		else $error("even value reported as prime");

endmodule

bind next_prime_search npsrch_checker u_npsrch_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.start_value(start_value),
	.opcode     (opcode),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.prime_value(prime_value),
	.found      (found)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for next_prime_search. A bit-accurate search model
// predicts the prime (or the miss) for every accepted request. A small ledger
// class checks each result, in order, against that prediction. Both
// channels idle at random, with one calm stretch and drain pauses.
// ----------------------------------------------------------------------------
module tb;
	import npsrch_pkg::*;

	localparam int unsigned W    = 32;
	localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - W);
	localparam logic [63:0] VSMAX = VMASK >> 1;
	// cycles to wait after the last result: the engine holds nothing once drained
	localparam int unsigned TAIL = 200;

	typedef struct {
		logic [31:0] start;
		logic [1:0]  op;
		logic [31:0] value;
		logic        found;
	} prime_hit_t;

	// Odd trial division, counting the divisions so that the run can budget
	// the block's own cycles. Even candidates never reach here.
	function automatic void trial_divide(input logic [63:0] n, output bit is_prime,
			output int unsigned trials);
		logic [63:0] d;
		trials   = 0;
		is_prime = (n > 1);
		for (d = FIRST_DIVISOR; d <= n / d; d += ODD_STRIDE) begin
			trials++;
			if (n % d == 0) begin
				is_prime = 0;
				break;
			end
		end
	endfunction

	class prime_ledger;
		prime_hit_t expected[$];
		int misses;

		function new();
			misses = 0;
		endfunction

		// Work out the search result for one accepted item and queue it.
		// Returns a rough upper bound on the block's cycles for the item.
		function longint note_item(logic [31:0] s, logic [1:0] op);
			prime_hit_t  e;
			logic [63:0] start, cand, stride;
			bit          down, need34, is_prime;
			int unsigned trials;
			longint      cost;
			start  = {32'd0, s} & VMASK;
			down   = (op == OP_DOWN_ANY) || (op == OP_DOWN_34);
			need34 = (op == OP_UP_34) || (op == OP_DOWN_34);
			stride = down ? ((64'd0 - ODD_STRIDE) & VMASK) : 64'(ODD_STRIDE);
			cand   = (start | 64'd1) & VMASK;
			cost   = 3;
			e.start = s;
			e.op    = op;
			e.value = start[31:0];
			e.found = 1'b0;
			while (cand < VSMAX && cand > 0) begin
				trial_divide(cand, is_prime, trials);
				cost += 1 + longint'(trials + 1) * (W + 2);
				if (is_prime && (!need34 || cand[1:0] == 2'b11)) begin
					e.value = cand[31:0];
					e.found = 1'b1;
					break;
				end
				cand = (cand + stride) & VMASK;
			end
			expected.push_back(e);
			return cost;
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			misses++;
		endtask

		task check_result(logic [31:0] pv, logic f);
			prime_hit_t e;
			if (expected.size() == 0) begin
				report($sformatf("result %h found=%b with nothing outstanding", pv, f));
				return;
			end
			e = expected.pop_front();
			if (pv !== e.value)
				report($sformatf("start %h op %0d: prime_value %h, want %h",
					e.start, e.op, pv, e.value));
			if (f !== e.found)
				report($sformatf("start %h op %0d: found %b, want %b",
					e.start, e.op, f, e.found));
		endtask

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] start_value = 32'd0;
	logic [1:0]  opcode = OP_UP_ANY;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] prime_value;
	logic        found;

	prime_ledger ledger = new();
	bit          calm = 1'b0;      // no idling on either side while set
	longint      cycles = 0;
	longint      deadline = 100000;

	const logic [1:0] all_ops[4] = '{OP_UP_ANY, OP_DOWN_ANY, OP_UP_34, OP_DOWN_34};
	const logic [1:0] up_ops[2]  = '{OP_UP_ANY, OP_UP_34};

	next_prime_search #(.VALUE_WIDTH(W)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_value (start_value),
		.opcode      (opcode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.prime_value (prime_value),
		.found       (found)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: the budget grows with the predicted work of every accepted item
	always @(posedge clk) begin
		cycles++;
		if (cycles > deadline) begin
			$display("[%0t] timeout after %0d cycles", $time, cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: check on each handshake, then stall at random for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_result(prime_value, found);
		out_ready <= calm || ($urandom_range(99) >= 38);
	end

	// Present one item and hold it until accepted. Called at the step of the
	// previous handshake, so valid stays high unless an idle gap is taken.
	task automatic send_item(input logic [31:0] s, input logic [1:0] op);
		if (!calm)
			while ($urandom_range(99) < 38) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid    <= 1'b1;
		start_value <= s;
		opcode      <= op;
		do @(posedge clk); while (!in_ready);
		deadline += 4 * ledger.note_item(s, op) + 400;
	endtask

	// Hold the sender back until every outstanding result has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.pending() != 0);
	endtask

	// Random request: mostly small starts so trial division stays short, a few
	// up to 2^20, and a few just under, at or beyond the signed limit, where
	// the search gives up at once or after a short upward run.
	task automatic pick_item(output logic [31:0] s, output logic [1:0] op);
		int unsigned tier;
		tier = $urandom_range(99);
		op   = all_ops[$urandom_range(3)];
		if (tier < 45)
			s = $urandom_range(255);
		else if (tier < 75)
			s = $urandom_range(4095, 256);
		else if (tier < 90)
			s = $urandom_range(65535, 4096);
		else if (tier < 93)
			s = $urandom_range(32'h0010_0000, 32'h0001_0000);
		else if (tier < 96) begin
			// at or just under the limit: only upward searches stay cheap here
			s = 32'h7FFF_FFFA + $urandom_range(5);
			if (s < 32'h7FFF_FFFE)
				op = up_ops[$urandom_range(1)];
		end else
			s = $urandom() | 32'h8000_0000;
	endtask

	initial begin
		logic [31:0] s;
		logic [1:0]  op;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero and one: upward finds 3, downward wraps past one and misses
		send_item(32'd0, OP_UP_ANY);
		send_item(32'd0, OP_DOWN_ANY);
		send_item(32'd0, OP_UP_34);
		send_item(32'd0, OP_DOWN_34);
		send_item(32'd1, OP_DOWN_ANY);
		send_item(32'd1, OP_DOWN_34);
		// Two is never returned; the search starts at three
		send_item(32'd2, OP_DOWN_ANY);
		send_item(32'd2, OP_DOWN_34);
		send_item(32'd3, OP_UP_34);
		// Skip primes that are 1 mod 4
		send_item(32'd5, OP_UP_34);
		send_item(32'd5, OP_DOWN_34);
		send_item(32'd9, OP_DOWN_ANY);
		// All ones and the signed limit: nothing tested, start echoed
		send_item(32'hFFFF_FFFF, OP_UP_ANY);
		send_item(32'hFFFF_FFFF, OP_DOWN_ANY);
		send_item(32'hFFFF_FFFF, OP_UP_34);
		send_item(32'hFFFF_FFFF, OP_DOWN_34);
		send_item(32'h7FFF_FFFF, OP_UP_ANY);
		send_item(32'h7FFF_FFFE, OP_DOWN_ANY);
		send_item(32'h8000_0000, OP_DOWN_34);
		// Upward into the limit through composites only
		send_item(32'h7FFF_FFFA, OP_UP_ANY);
		send_item(32'h7FFF_FFFC, OP_UP_34);
		// A few deeper searches
		send_item(32'd1000000, OP_UP_ANY);
		send_item(32'd1048575, OP_DOWN_34);
		send_item(32'd65521, OP_UP_ANY);
		drain();

		for (int i = 0; i < 600; i++) begin
			if (i == 250)
				calm = 1'b1;
			if (i == 400)
				calm = 1'b0;
			if (i == 450)
				drain();
			pick_item(s, op);
			send_item(s, op);
		end
		in_valid <= 1'b0;

		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (ledger.misses == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> next_prime_search.f
rtl/npsrch_pkg.sv
rtl/npsrch_div.sv
rtl/next_prime_search.sv
rtl/npsrch_checker.sv
dv/tb.sv
